@@ src/pdc_pkg.sv @@
// Shared types, constants and the CRC-8 byte update for the packet deframer.
package pdc_pkg;

    localparam logic [7:0] CRC_POLY     = 8'h07;
    localparam logic [8:0] POS_MAX      = 9'd511;
    localparam logic [8:0] CMD_MIN_POS  = 9'd3;   // first data byte, command layout
    localparam logic [8:0] RESP_MIN_POS = 9'd5;   // first data byte out, response layout

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_SHORT    = 2'd1;
    localparam logic [1:0] ERR_MISMATCH = 2'd2;

    // One queued result: a data beat or an end-of-packet summary.
    typedef struct packed {
        logic        kind;
        logic [7:0]  byte_val;   // data byte, or received CRC byte in a summary
        logic [7:0]  code;
        logic [7:0]  len;
        logic [7:0]  seq;
        logic [15:0] status;
        logic [7:0]  crc_calc;
        logic        resp;
        logic [1:0]  err;
    } t_rec;

    // MSB-first CRC-8, no reflection, no final xor.
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            v = {v[6:0], 1'b0} ^ (v[7] ? CRC_POLY : 8'h00);
        end
        return v;
    endfunction

endpackage

@@ src/pdc_front.sv @@
// Front end: tracks packet position, header fields and CRC, emits result records.
module pdc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_response_mode,
    input  logic          i_accept,
    input  logic [7:0]    i_rx_byte,
    input  logic          i_last_byte,
    output logic          o_push,
    output pdc_pkg::t_rec o_rec
);
    import pdc_pkg::*;

    logic       r_resp;
    logic [8:0] r_pos,  n_pos;
    logic [7:0] r_crc,  n_crc;
    logic [7:0] r_code, n_code;
    logic [7:0] r_len,  n_len;
    logic [7:0] r_seq,  n_seq;
    logic [7:0] r_rec0, n_rec0;   // previous byte
    logic [7:0] r_rec1, n_rec1;   // byte before that
    logic [7:0] crc_code, crc_two, crc_cur;

    assign crc_code = crc8_next(8'h00, r_code);
    assign crc_two  = crc8_next(crc_code, i_rx_byte);
    assign crc_cur  = crc8_next(r_crc, i_rx_byte);

    always_comb begin
        n_pos  = r_pos;
        n_crc  = r_crc;
        n_code = r_code;
        n_len  = r_len;
        n_seq  = r_seq;
        n_rec0 = r_rec0;
        n_rec1 = r_rec1;
        o_push = 1'b0;
        o_rec  = '0;
        if (i_accept) begin
            if (r_pos == 9'd0) begin
                n_code = i_rx_byte;
            end else if (r_pos == 9'd1) begin
                n_len = i_rx_byte;
                if (i_rx_byte >= 8'd2) begin
                    n_crc = crc_two;
                end else if (i_rx_byte >= 8'd1) begin
                    n_crc = crc_code;
                end else begin
                    n_crc = 8'h00;
                end
            end else begin
                if (r_pos == 9'd2) begin
                    n_seq = i_rx_byte;
                end
                if (r_pos < {1'b0, r_len}) begin
                    n_crc = crc_cur;
                end
            end

            if (i_last_byte) begin
                o_push         = 1'b1;
                o_rec.kind     = KIND_SUMMARY;
                o_rec.byte_val = i_rx_byte;
                o_rec.code     = n_code;
                o_rec.len      = n_len;
                o_rec.seq      = n_seq;
                o_rec.status   = r_resp ? {r_rec1, r_rec0} : 16'h0000;
                o_rec.crc_calc = n_crc;
                o_rec.resp     = r_resp;
                if (r_pos != {1'b0, n_len}) begin
                    o_rec.err = ERR_MISMATCH;
                end else if (r_pos < (r_resp ? RESP_MIN_POS : CMD_MIN_POS)) begin
                    o_rec.err = ERR_SHORT;
                end else begin
                    o_rec.err = ERR_OK;
                end
                n_pos  = '0;
                n_crc  = '0;
                n_code = '0;
                n_len  = '0;
                n_seq  = '0;
                n_rec0 = '0;
                n_rec1 = '0;
            end else begin
                if (!r_resp && r_pos >= CMD_MIN_POS) begin
                    o_push         = 1'b1;
                    o_rec.kind     = KIND_DATA;
                    o_rec.byte_val = i_rx_byte;
                end else if (r_resp && r_pos >= RESP_MIN_POS) begin
                    // response data trails by two beats so the status word never leaks
                    o_push         = 1'b1;
                    o_rec.kind     = KIND_DATA;
                    o_rec.byte_val = r_rec1;
                end
                n_rec1 = r_rec0;
                n_rec0 = i_rx_byte;
                if (r_pos != POS_MAX) begin
                    n_pos = r_pos + 9'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resp <= 1'b0;
            r_pos  <= '0;
            r_crc  <= '0;
            r_code <= '0;
            r_len  <= '0;
            r_seq  <= '0;
            r_rec0 <= '0;
            r_rec1 <= '0;
        end else begin
            if (i_cfg_we) begin
                r_resp <= i_cfg_response_mode;
            end
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_code <= n_code;
            r_len  <= n_len;
            r_seq  <= n_seq;
            r_rec0 <= n_rec0;
            r_rec1 <= n_rec1;
        end
    end

endmodule

@@ src/pdc_fifo.sv @@
// Result queue between front and back end.
module pdc_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pdc_pkg::t_rec i_rec,
    input  logic          i_pop,
    output pdc_pkg::t_rec o_rec,
    output logic          o_full,
    output logic          o_empty
);
    import pdc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_rec          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ src/pdc_back.sv @@
// Back end: formats the queue head into result fields and does the CRC check.
module pdc_back (
    input  pdc_pkg::t_rec i_rec,
    output logic          o_kind,
    output logic [7:0]    o_data_byte,
    output logic [7:0]    o_first_byte,
    output logic [7:0]    o_length_field,
    output logic [7:0]    o_sequence_res,
    output logic [15:0]   o_status_word,
    output logic [7:0]    o_crc_byte,
    output logic          o_crc_ok,
    output logic [1:0]    o_error_code,
    output logic          o_last
);
    import pdc_pkg::*;

    logic summ;
    assign summ = (i_rec.kind == KIND_SUMMARY);

    assign o_kind         = i_rec.kind;
    assign o_data_byte    = summ ? 8'h00 : i_rec.byte_val;
    assign o_first_byte   = summ ? i_rec.code : 8'h00;
    assign o_length_field = summ ? i_rec.len : 8'h00;
    // response layout keeps only the upper nibble of the sequence byte
    assign o_sequence_res = !summ      ? 8'h00 :
                            i_rec.resp ? {4'h0, i_rec.seq[7:4]} : i_rec.seq;
    assign o_status_word  = summ ? i_rec.status : 16'h0000;
    assign o_crc_byte     = summ ? i_rec.byte_val : 8'h00;
    assign o_crc_ok       = summ && (i_rec.crc_calc == i_rec.byte_val);
    assign o_error_code   = summ ? i_rec.err : ERR_OK;
    assign o_last         = 1'b1;

endmodule

@@ src/packet_deframer_crc8.sv @@
// A result beat is written into the result queue at the clock edge that accepts the input beat that causes it.
// Throughput: one input beat per cycle while full is low; each beat yields at most one result beat.
// full rises only while the result queue holds QUEUE_DEPTH beats nobody has popped.
// Reset is synchronous, active low: queue emptied, packet state cleared, command layout.
// No clearing pass; the block takes beats from the first cycle after reset.
module packet_deframer_crc8 #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_response_mode,
    // input queue side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_last_byte,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic        o_kind,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_first_byte,
    output logic [7:0]  o_length_field,
    output logic [7:0]  o_sequence_res,
    output logic [15:0] o_status_word,
    output logic [7:0]  o_crc_byte,
    output logic        o_crc_ok,
    output logic [1:0]  o_error_code,
    output logic        o_last
);
    import pdc_pkg::*;

    logic accept;
    logic rec_push;
    t_rec rec_in;
    t_rec rec_head;

    // a beat is taken whenever the queue has room for its possible result
    assign accept = push && !full;

    // Front: header capture, bytewise CRC-8, data/summary classification.
    pdc_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_response_mode (i_cfg_response_mode),
        .i_accept            (accept),
        .i_rx_byte           (i_rx_byte),
        .i_last_byte         (i_last_byte),
        .o_push              (rec_push),
        .o_rec               (rec_in)
    );

    // Queue decouples the byte stream from a stalling consumer.
    pdc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_rec   (rec_in),
        .i_pop   (pop),
        .o_rec   (rec_head),
        .o_full  (full),
        .o_empty (empty)
    );

    // Back: field formatting and CRC compare on the oldest queued beat.
    pdc_back u_back (
        .i_rec          (rec_head),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_first_byte   (o_first_byte),
        .o_length_field (o_length_field),
        .o_sequence_res (o_sequence_res),
        .o_status_word  (o_status_word),
        .o_crc_byte     (o_crc_byte),
        .o_crc_ok       (o_crc_ok),
        .o_error_code   (o_error_code),
        .o_last         (o_last)
    );

endmodule

@@ src/pdc_checker.sv @@
// Port-level checks for the packet deframer, bound to the top level.
module pdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        o_kind,
    input logic [7:0]  o_first_byte,
    input logic [7:0]  o_data_byte,
    input logic        o_crc_ok,
    input logic [1:0]  o_error_code,
    input logic        o_last
);
    import pdc_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue not cleared by reset");

    a_last_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_last)
        else $error("result beat without last");

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_DATA) |->
        (o_first_byte == 8'h00 && !o_crc_ok && o_error_code == ERR_OK))
        else $error("data beat carries summary fields");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_error_code == ERR_OK || o_error_code == ERR_SHORT ||
                    o_error_code == ERR_MISMATCH))
        else $error("undefined error code");

    a_summary_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_SUMMARY) |-> (o_data_byte == 8'h00))
        else $error("summary beat carries a data byte");

endmodule

bind packet_deframer_crc8 pdc_checker u_pdc_checker (.*);

@@ tb/tb_packet_deframer_crc8.sv @@
// Self-checking bench for packet_deframer_crc8: byte-level predictor, scoreboard and drivers.
package tb_deframer_pkg;
    import pdc_pkg::*;

    // One result beat as it appears on the block's outputs
    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  first_byte;
        logic [7:0]  length_field;
        logic [7:0]  sequence_res;
        logic [15:0] status_word;
        logic [7:0]  crc_byte;
        logic        crc_ok;
        logic [1:0]  error_code;
        logic        last;
    } deframed_t;

    class deframer_scoreboard;
        bit          resp_mode;
        logic [8:0]  pos;
        logic [7:0]  crc_acc;
        logic [7:0]  code_b;
        logic [7:0]  len_b;
        logic [7:0]  seq_b;
        logic [7:0]  newer;     // previous byte
        logic [7:0]  older;     // the one before that
        deframed_t   expected_beats[$];
        int          errors;

        function new();
            resp_mode = 1'b0;
            errors    = 0;
            clear_packet();
        endfunction

        // MSB first, poly 0x07, no reflection, no final xor
        static function logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
            logic [7:0] acc;
            acc = crc ^ b;
            repeat (8) acc = acc[7] ? ((acc << 1) ^ CRC_POLY) : (acc << 1);
            return acc;
        endfunction

        function void clear_packet();
            pos     = '0;
            crc_acc = '0;
            code_b  = '0;
            len_b   = '0;
            seq_b   = '0;
            newer   = '0;
            older   = '0;
        endfunction

        function void set_mode(bit m);
            resp_mode = m;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        // Note one accepted input beat and queue whatever it should produce
        function void take_byte(logic [7:0] b, logic fin);
            logic [8:0] p;
            deframed_t  r;
            p = pos;
            r = '0;
            if (p == 9'd0) begin
                code_b = b;
            end else if (p == 9'd1) begin
                len_b   = b;
                crc_acc = 8'h00;
                if (len_b >= 8'd1) crc_acc = crc8_step(crc_acc, code_b);
                if (len_b >= 8'd2) crc_acc = crc8_step(crc_acc, b);
            end else begin
                if (p == 9'd2) seq_b = b;
                if (p < {1'b0, len_b}) crc_acc = crc8_step(crc_acc, b);
            end

            if (fin) begin
                r.kind         = KIND_SUMMARY;
                r.first_byte   = code_b;
                r.length_field = len_b;
                if (p >= 9'd2) r.sequence_res = resp_mode ? {4'h0, seq_b[7:4]} : seq_b;
                if (resp_mode) r.status_word = {older, newer};
                r.crc_byte = b;
                r.crc_ok   = (crc_acc == b);
                if (p != {1'b0, len_b})
                    r.error_code = ERR_MISMATCH;
                else if (p < (resp_mode ? RESP_MIN_POS : CMD_MIN_POS))
                    r.error_code = ERR_SHORT;
                else
                    r.error_code = ERR_OK;
                r.last = 1'b1;
                expected_beats.push_back(r);
                clear_packet();
            end else begin
                if (!resp_mode && p >= CMD_MIN_POS) begin
                    r.kind      = KIND_DATA;
                    r.data_byte = b;
                    r.last      = 1'b1;
                    expected_beats.push_back(r);
                end else if (resp_mode && p >= RESP_MIN_POS) begin
                    // delayed by two so the status word never leaks out
                    r.kind      = KIND_DATA;
                    r.data_byte = older;
                    r.last      = 1'b1;
                    expected_beats.push_back(r);
                end
                older = newer;
                newer = b;
                if (pos < POS_MAX) pos = pos + 9'd1;
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_beat(deframed_t got);
            deframed_t want;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            compare_field("kind",         want.kind,         got.kind);
            compare_field("data_byte",    want.data_byte,    got.data_byte);
            compare_field("first_byte",   want.first_byte,   got.first_byte);
            compare_field("length_field", want.length_field, got.length_field);
            compare_field("sequence_res", want.sequence_res, got.sequence_res);
            compare_field("status_word",  want.status_word,  got.status_word);
            compare_field("crc_byte",     want.crc_byte,     got.crc_byte);
            compare_field("crc_ok",       want.crc_ok,       got.crc_ok);
            compare_field("error_code",   want.error_code,   got.error_code);
            compare_field("last",         want.last,         got.last);
        endfunction
    endclass

endpackage

module tb_packet_deframer_crc8;
    timeunit 1ns;
    timeprecision 1ps;

    import pdc_pkg::*;
    import tb_deframer_pkg::*;

    // Cycles with no beat moving on either side before we give up; the
    // config pause is one legitimate quiet spell.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_BEATS    = 90;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we  = 1'b0;
    logic        cfg_mode = 1'b0;
    logic        push    = 1'b0;
    logic [7:0]  rx_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        pop     = 1'b0;

    logic        full;
    logic        empty;
    logic        o_kind;
    logic [7:0]  o_data_byte;
    logic [7:0]  o_first_byte;
    logic [7:0]  o_length_field;
    logic [7:0]  o_sequence_res;
    logic [15:0] o_status_word;
    logic [7:0]  o_crc_byte;
    logic        o_crc_ok;
    logic [1:0]  o_error_code;
    logic        o_last;

    deframer_scoreboard sb = new();
    bit        idle_en = 1'b1;      // random idling on both sides
    int        beats_sent = 0;
    int        quiet_cycles = 0;
    deframed_t seen;

    packet_deframer_crc8 DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_response_mode (cfg_mode),
        .push                (push),
        .full                (full),
        .i_rx_byte           (rx_byte),
        .i_last_byte         (last_byte),
        .empty               (empty),
        .pop                 (pop),
        .o_kind              (o_kind),
        .o_data_byte         (o_data_byte),
        .o_first_byte        (o_first_byte),
        .o_length_field      (o_length_field),
        .o_sequence_res      (o_sequence_res),
        .o_status_word       (o_status_word),
        .o_crc_byte          (o_crc_byte),
        .o_crc_ok            (o_crc_ok),
        .o_error_code        (o_error_code),
        .o_last              (o_last)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Result side: hold pop low at random, about 9 percent of the time, unless in a quiet phase
    always @(posedge i_clk) begin
        pop <= !(idle_en && $urandom_range(99) < 9);
    end

    // Outputs and handshakes are stable mid-cycle, so sample at the falling
    // edge: a beat seen here with pop high is taken at the next rising edge.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                seen.kind         = o_kind;
                seen.data_byte    = o_data_byte;
                seen.first_byte   = o_first_byte;
                seen.length_field = o_length_field;
                seen.sequence_res = o_sequence_res;
                seen.status_word  = o_status_word;
                seen.crc_byte     = o_crc_byte;
                seen.crc_ok       = o_crc_ok;
                seen.error_code   = o_error_code;
                seen.last         = o_last;
                sb.check_beat(seen);
            end
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired with %0d beats outstanding",
                         $time, sb.pending());
                $display("tb_packet_deframer_crc8 NOT OK");
                $finish;
            end
        end
    end

    // Present one input beat and hold it until taken. Called at a rising
    // edge and returns at the rising edge where the beat was accepted;
    // push stays high so back-to-back beats need no re-raise.
    task automatic send_beat(input logic [7:0] b, input logic fin);
        bit taken;
        while (idle_en && $urandom_range(99) < 9) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        rx_byte   <= b;
        last_byte <= fin;
        do begin
            @(negedge i_clk);
            taken = !full;
            if (taken) sb.take_byte(b, fin);
            @(posedge i_clk);
        end while (!taken);
        beats_sent++;
    endtask

    // closed = 0 leaves the packet open (no final flag on its last byte)
    task automatic send_packet(input logic [7:0] pkt[$], input bit closed);
        foreach (pkt[i]) send_beat(pkt[i], closed && (i == pkt.size() - 1));
    endtask

    // Only while idle: drain results, let in-flight work settle, then write
    task automatic set_layout(input bit m);
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_mode <= m;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.set_mode(m);
    endtask

    function automatic void append_crc(ref logic [7:0] pkt[$], input int span);
        logic [7:0] crc;
        crc = 8'h00;
        for (int i = 0; i < span; i++) crc = deframer_scoreboard::crc8_step(crc, pkt[i]);
        pkt.push_back(crc);
    endfunction

    // Well-formed packet: code, length, sequence, payload, [status], CRC
    function automatic void build_packet(ref logic [7:0] pkt[$], input bit resp, input int n);
        int span;
        span = (resp ? 5 : 3) + n;
        pkt.delete();
        pkt.push_back(8'($urandom));
        pkt.push_back(8'(span));
        pkt.push_back(8'($urandom));
        repeat (n) pkt.push_back(8'($urandom));
        if (resp) begin
            pkt.push_back(8'($urandom));
            pkt.push_back(8'($urandom));
        end
        append_crc(pkt, span);
    endfunction

    // Mostly good packets with random content; the rest broken or noise
    function automatic void random_packet(ref logic [7:0] pkt[$], input bit resp);
        int n;
        int shape;
        int k;
        n = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 8);
        build_packet(pkt, resp, n);
        shape = $urandom_range(99);
        if (shape < 68) begin
            // left intact
        end else if (shape < 78) begin
            pkt[pkt.size() - 1] ^= 8'($urandom_range(1, 255));      // corrupt CRC
        end else if (shape < 86) begin
            pkt[1] = 8'($urandom);                                  // wrong length byte
        end else if (shape < 94) begin
            // cut short; sometimes with a length byte that agrees
            k = $urandom_range(1, 5);
            while (pkt.size() > k) void'(pkt.pop_back());
            if (k >= 2 && $urandom_range(1)) pkt[1] = 8'(k - 1);
        end else begin
            pkt.delete();
            repeat ($urandom_range(1, 20)) pkt.push_back(8'($urandom));
        end
    endfunction

    task automatic run_phase(input bit m, input bit quiet);
        logic [7:0] pkt[$];
        int start;
        set_layout(m);
        idle_en = !quiet;
        start = beats_sent;
        while (beats_sent - start < PHASE_BEATS) begin
            random_packet(pkt, m);
            send_packet(pkt, 1'b1);
        end
        idle_en = 1'b1;
    endtask

    initial begin
        logic [7:0] pkt[$];

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed, command layout ----
        // minimal good packet, header bytes at the extremes
        pkt = '{8'h00, 8'h03, 8'hFF};
        append_crc(pkt, 3);
        send_packet(pkt, 1'b1);
        // lone byte flagged final: CRC at position 0, too short
        pkt = '{8'hFF};
        send_packet(pkt, 1'b1);
        // CRC at position 1 with a matching length byte: too short
        pkt = '{8'hA5, 8'h01};
        send_packet(pkt, 1'b1);
        // length beyond the CRC position: mismatch, CRC span takes in the CRC byte
        pkt = '{8'h12, 8'hFF, 8'h34, 8'h56};
        send_packet(pkt, 1'b1);

        // layout switched halfway through a packet
        set_layout(1'b1);
        pkt = '{8'h80, 8'h05, 8'h3C};
        send_packet(pkt, 1'b0);
        set_layout(1'b0);
        pkt = '{8'h01, 8'h02};
        send_packet(pkt, 1'b1);

        // ---- directed, response layout ----
        set_layout(1'b1);
        pkt = '{8'h7E, 8'h06, 8'hA7, 8'h5A, 8'hFF, 8'h00};
        append_crc(pkt, 6);
        send_packet(pkt, 1'b1);
        // consistent length but under the response minimum
        pkt = '{8'hC3, 8'h04, 8'h9F, 8'h00, 8'hFF};
        send_packet(pkt, 1'b1);

        // ---- random phases; third one without any idling ----
        run_phase(1'b0, 1'b0);
        run_phase(1'b1, 1'b0);
        run_phase(1'b1, 1'b1);
        run_phase(1'b0, 1'b0);
        run_phase(1'b1, 1'b0);
        run_phase(1'b0, 1'b0);

        // drain, then give a late or spurious beat the chance to show up
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_packet_deframer_crc8 OK");
        end else begin
            $display("tb_packet_deframer_crc8 NOT OK");
        end
        $finish;
    end

endmodule
